/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the formatter RTL; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i, off during reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
// Next-cycle implication, sampled on clk_i, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/dafmt_pkg.sv */
// Package: constants and elaboration helpers of the decimal ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none
package dafmt_pkg;

  localparam int unsigned VALUE_BITS_DEF = 31;
  localparam int unsigned MAX_PAD_DEF    = 15;
  localparam int unsigned PAD_W          = 4;
  localparam int unsigned CHAR_W         = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Decimal digits needed for the largest value of the given bit count
  function automatic int unsigned num_digits(input int unsigned bits);
    longint unsigned v;
    int unsigned     n;
    v = (64'd1 << bits) - 64'd1;
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 0) begin
        v = v / 10;
        n++;
      end
    end
    return n;
  endfunction

  function automatic int unsigned max_int(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/dafmt_in_if.sv */
// Interface: request channel carrying a value and its pad width.
`timescale 1ns / 1ps
`default_nettype none
interface dafmt_in_if
  import dafmt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [PAD_W-1:0]      pad_width;

  modport source (output valid, output value, output pad_width, input ready);
  modport sink   (input valid, input value, input pad_width, output ready);
endinterface
`default_nettype wire

/* hw/rtl/dafmt_out_if.sv */
// Interface: character channel carrying one ASCII digit and a last flag.
`timescale 1ns / 1ps
`default_nettype none
interface dafmt_out_if
  import dafmt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface
`default_nettype wire

/* hw/rtl/decimal_ascii_formatter_core.sv */
// Conversion: shift-and-add-3 over all VALUE_BITS bits in the front end, then a queue hand-off.
// Emission: one character per cycle while the output is ready, from the back end's output
// register, 1 to max(MAX_PAD, NDIG) characters per item.
// The front end accepts no new request until it has handed its current item to the queue.
// Reset (rst_ni low, asynchronous) empties the queue and drops any item in progress.
`timescale 1ns / 1ps
`default_nettype none
module decimal_ascii_formatter_core
  import dafmt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_PAD    = MAX_PAD_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dafmt_in_if.sink    req_i,
  dafmt_out_if.source rsp_o
);

  localparam int unsigned NDIG  = num_digits(VALUE_BITS);
  localparam int unsigned BCD_W = NDIG * 4;
  localparam int unsigned SPAN  = max_int(MAX_PAD, NDIG);
  localparam int unsigned IDX_W = $clog2(SPAN);
  localparam int unsigned CNT_W = $clog2(SPAN + 1);
  localparam int unsigned ENT_W = BCD_W + IDX_W + CNT_W;

  logic             push_valid, push_ready;
  logic [ENT_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [ENT_W-1:0] pop_data;

  dafmt_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_PAD   (MAX_PAD)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  dafmt_queue #(
    .WIDTH(ENT_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  dafmt_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_PAD   (MAX_PAD)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .rsp_o      (rsp_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/dafmt_front.sv */
// Front end: accepts a request and converts it to BCD by shift-and-add-3.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dafmt_front
  import dafmt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_PAD    = MAX_PAD_DEF,
  localparam int unsigned NDIG  = num_digits(VALUE_BITS),
  localparam int unsigned BCD_W = NDIG * 4,
  localparam int unsigned SPAN  = max_int(MAX_PAD, NDIG),
  localparam int unsigned IDX_W = $clog2(SPAN),
  localparam int unsigned CNT_W = $clog2(SPAN + 1),
  localparam int unsigned ENT_W = BCD_W + IDX_W + CNT_W
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  dafmt_in_if.sink        req_i,
  output logic            push_valid_o,
  input  wire logic       push_ready_i,
  output logic [ENT_W-1:0] push_data_o
);

  localparam int unsigned BIT_W = $clog2(VALUE_BITS);
  localparam int unsigned CMP_W = max_int(CNT_W, PAD_W);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e          state_q, state_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [BIT_W-1:0]      bit_q, bit_d;
  logic [PAD_W-1:0]      pad_q, pad_d;

  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      len;
  logic [CNT_W-1:0]      pad_sat;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      span_top;
  logic [IDX_W-1:0]      start;

  // Add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                      : bcd_q[i*4 +: 4];
    end
  end

  // Significant digit count, at least one
  always_comb begin
    len = CNT_W'(1);
    for (int i = 1; i < NDIG; i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) len = CNT_W'(i + 1);
    end
  end

  // Clamp the pad width, pick the character count and the first digit index
  always_comb begin
    if (CMP_W'(pad_q) > CMP_W'(MAX_PAD)) pad_sat = CNT_W'(MAX_PAD);
    else pad_sat = CNT_W'(pad_q);
    count    = (pad_q != '0) ? pad_sat : len;
    span_top = (count > len) ? count : len;
    start    = IDX_W'(span_top - CNT_W'(1));
  end

  // Sequence: load, shift one bit per cycle, hand the result to the queue
  always_comb begin
    state_d = state_q;
    val_d   = val_q;
    bcd_d   = bcd_q;
    bit_d   = bit_q;
    pad_d   = pad_q;
    unique case (state_q)
      F_IDLE: begin
        if (req_i.valid) begin
          val_d   = req_i.value;
          pad_d   = req_i.pad_width;
          bcd_d   = '0;
          bit_d   = BIT_W'(VALUE_BITS - 1);
          state_d = F_CONV;
        end
      end
      F_CONV: begin
        bcd_d = {bcd_adj[BCD_W-2:0], val_q[VALUE_BITS-1]};
        val_d = {val_q[VALUE_BITS-2:0], 1'b0};
        bit_d = bit_q - BIT_W'(1);
        if (bit_q == '0) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign req_i.ready  = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_data_o  = {bcd_q, start, count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    bcd_q <= bcd_d;
    bit_q <= bit_d;
    pad_q <= pad_d;
  end

  `ASSERT_NEXT(a_conv_ends_in_push, (state_q == F_CONV) && (bit_q == '0), state_q == F_PUSH)
  `ASSERT_IMP(a_no_accept_while_busy, state_q != F_IDLE, !req_i.ready)

endmodule
`default_nettype wire

/* hw/rtl/dafmt_queue.sv */
// Two-entry queue between the converter and the character emitter.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dafmt_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  `ASSERT_IMP(a_cnt_bounded, 1'b1, cnt_q != 2'd3)
  `ASSERT_IMP(a_ptrs_match_cnt, (cnt_q == 2'd0) || (cnt_q == 2'd2), wr_q == rd_q)

endmodule
`default_nettype wire

/* hw/rtl/dafmt_back.sv */
// Back end: emits the digits of one queued entry as ASCII, one per cycle while the output is ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dafmt_back
  import dafmt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_PAD    = MAX_PAD_DEF,
  localparam int unsigned NDIG  = num_digits(VALUE_BITS),
  localparam int unsigned BCD_W = NDIG * 4,
  localparam int unsigned SPAN  = max_int(MAX_PAD, NDIG),
  localparam int unsigned IDX_W = $clog2(SPAN),
  localparam int unsigned CNT_W = $clog2(SPAN + 1),
  localparam int unsigned ENT_W = BCD_W + IDX_W + CNT_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  output logic                  pop_ready_o,
  input  wire logic [ENT_W-1:0] pop_data_i,
  dafmt_out_if.source           rsp_o
);

  localparam int unsigned DIG_IW = $clog2(NDIG);

  logic              active_q;
  logic [3:0]        digits_q [NDIG];
  logic [IDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]  rem_q;
  logic              out_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  logic              slot_free;
  logic              emit;
  logic              load;
  logic              in_range;
  logic [3:0]        digit;

  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign emit        = active_q && slot_free;
  assign pop_ready_o = !active_q;
  assign load        = pop_valid_i && !active_q;

  // Positions above the top digit read as zero
  assign in_range = ({1'b0, idx_q} < (IDX_W + 1)'(NDIG));
  assign digit    = in_range ? digits_q[idx_q[DIG_IW-1:0]] : 4'd0;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.ascii_char = char_q;
  assign rsp_o.last_char  = last_q;

  // Control: take an entry when idle, drop it after its last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) active_q <= 1'b1;
      else if (emit && (rem_q == CNT_W'(1))) active_q <= 1'b0;
      if (emit) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload: unpack the entry, step the digit index, fill the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < NDIG; i++) begin
        digits_q[i] <= pop_data_i[ENT_W-BCD_W+i*4 +: 4];
      end
      idx_q <= pop_data_i[CNT_W +: IDX_W];
      rem_q <= pop_data_i[CNT_W-1:0];
    end else if (emit) begin
      idx_q <= idx_q - IDX_W'(1);
      rem_q <= rem_q - CNT_W'(1);
    end
    if (emit) begin
      char_q <= ASCII_ZERO + {2'b00, digit};
      last_q <= (rem_q == CNT_W'(1));
    end
  end

  `ASSERT_IMP(a_active_has_chars, active_q, rem_q != '0)
  `ASSERT_NEXT(a_mid_char_keeps_active, emit && (rem_q != CNT_W'(1)), active_q)

endmodule
`default_nettype wire
